### src/zhb_pkg.sv
// ----------------------------------------------------------------------------
// zhb_pkg
// Shared types, constants and arithmetic helpers for the D2Q9 Zou-He
// boundary pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package zhb_pkg;

  localparam int unsigned QW    = 32;
  localparam int unsigned NPOP  = 9;
  localparam int unsigned QFRAC = 24;
  localparam int unsigned NNB   = 4;

  typedef logic signed [QW-1:0] q_t;
  typedef logic [NPOP-1:0][QW-1:0] pop_vec_t;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_MODE     = 2'd0;
  localparam cfg_idx_t CFG_PRESSURE = 2'd1;
  localparam cfg_idx_t CFG_GAIN     = 2'd2;

  typedef enum logic {
    MODE_VELOCITY = 1'b0,
    MODE_PRESSURE = 1'b1
  } bmode_e;

  // Open side codes, in match priority order
  typedef logic [1:0] side_t;
  localparam side_t SIDE_5 = 2'd0;
  localparam side_t SIDE_1 = 2'd1;
  localparam side_t SIDE_7 = 2'd2;
  localparam side_t SIDE_3 = 2'd3;

  // Reciprocal of 3 for 20-bit operands: floor(n/3) = (n*M) >> 21
  localparam int unsigned  DIV3_W     = 20;
  localparam int unsigned  DIV3_SHIFT = DIV3_W + 1;
  localparam logic [DIV3_W-1:0] DIV3_M = 20'hAAAAB;

  // High/low split of the offset dividend
  localparam int unsigned YW  = 35;
  localparam int unsigned YLO = 18;
  localparam int unsigned YHI = YW - YLO;
  // Offset that makes the signed dividend nonnegative (3 * 2^32)
  localparam logic signed [YW:0] Y_OFS = 36'sh3_0000_0000;
  localparam logic signed [YW:0] Q_OFS = 36'sh1_0000_0000;

  localparam logic signed [39:0] SAT_MAX = 40'sh00_7FFF_FFFF;
  localparam logic signed [39:0] SAT_MIN = -40'sh00_8000_0000;

  typedef struct packed {
    pop_vec_t pops;
    side_t    side;
    logic     nos;
  } hdr_t;

  // Operands that ride along to the final update
  typedef struct packed {
    q_t                 a3;
    q_t                 a6;
    q_t                 a7;
    logic signed [32:0] h;
  } fix_t;

  typedef struct packed {
    hdr_t               hdr;
    logic signed [33:0] sa;
    logic signed [33:0] sb;
    logic signed [33:0] dh;
    q_t                 a3;
    q_t                 a6;
    q_t                 a7;
  } s1_t;

  typedef struct packed {
    hdr_t hdr;
    q_t   s;
    fix_t fx;
  } s2_t;

  typedef struct packed {
    hdr_t               hdr;
    q_t                 s;
    logic signed [63:0] prod;
    fix_t               fx;
  } s3_t;

  typedef struct packed {
    hdr_t          hdr;
    logic [YW-1:0] y1;
    logic [YW-1:0] y2;
    fix_t          fx;
  } s4_t;

  typedef struct packed {
    hdr_t              hdr;
    logic [YHI-1:0]    qh1;
    logic [YHI-1:0]    qh2;
    logic [DIV3_W-1:0] n1;
    logic [DIV3_W-1:0] n2;
    fix_t              fx;
  } s5_t;

  typedef struct packed {
    hdr_t hdr;
    q_t   t23;
    q_t   w6;
    fix_t fx;
  } s6_t;

  // Index map i1..i8 of one side, one nibble per position
  function automatic logic [31:0] map_row(input side_t side);
    logic [31:0] row;
    unique case (side)
      SIDE_5:  row = 32'h8642_7531;
      SIDE_1:  row = 32'h6824_7135;
      SIDE_7:  row = 32'h2864_1753;
      SIDE_3:  row = 32'h6428_5317;
      default: row = 32'h8642_7531;
    endcase
    return row;
  endfunction

  function automatic logic [3:0] map_idx(input side_t side, input logic [2:0] pos);
    logic [31:0] row;
    row = map_row(side);
    return row[{pos, 2'b00} +: 4];
  endfunction

  function automatic q_t sat40(input logic signed [39:0] v);
    q_t r;
    if (v > SAT_MAX) begin
      r = q_t'(SAT_MAX[31:0]);
    end else if (v < SAT_MIN) begin
      r = q_t'(SAT_MIN[31:0]);
    end else begin
      r = q_t'(v[31:0]);
    end
    return r;
  endfunction

  // floor(n/3) for n < 2^20
  function automatic logic [DIV3_W-1:0] div3(input logic [DIV3_W-1:0] n);
    logic [2*DIV3_W-1:0] p;
    p = (2*DIV3_W)'(n) * (2*DIV3_W)'(DIV3_M);
    return DIV3_W'(p[2*DIV3_W-1:DIV3_SHIFT]);
  endfunction

endpackage

`default_nettype wire

### src/zhb_front.sv
// ----------------------------------------------------------------------------
// zhb_front
// Stages 1-2: open side decode, operand gather, density sum and half
// difference.
// ----------------------------------------------------------------------------
`default_nettype none

module zhb_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  zhb_pkg::pop_vec_t  pops_i,
  input  logic [3:0]         present_i,
  input  logic [3:0]         fluid_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output zhb_pkg::s2_t       out_data_o
);
  import zhb_pkg::*;

  // Neighbour flag bit positions
  localparam int unsigned NB_1 = 0;
  localparam int unsigned NB_3 = 1;
  localparam int unsigned NB_5 = 2;
  localparam int unsigned NB_7 = 3;

  logic       v1_q, v2_q;
  logic       rdy1, rdy2;
  s1_t        d1_d, d1_q;
  s2_t        d2_d, d2_q;
  logic [3:0] fl;
  logic [3:0] match;
  q_t         f0, a2, a3, a4, a6, a7;

  // Stage 1: pick the side, gather operands
  always_comb begin
    fl = fluid_i & present_i;
    match[SIDE_5] = ~present_i[NB_5] | (~fl[NB_5] & fl[NB_1]);
    match[SIDE_1] = ~present_i[NB_1] | (~fl[NB_1] & fl[NB_5]);
    match[SIDE_7] = ~present_i[NB_7] | (~fl[NB_7] & fl[NB_3]);
    match[SIDE_3] = ~present_i[NB_3] | (~fl[NB_3] & fl[NB_7]);

    d1_d.hdr.pops = pops_i;
    d1_d.hdr.nos  = 1'b0;
    priority if (match[SIDE_5]) begin
      d1_d.hdr.side = SIDE_5;
    end else if (match[SIDE_1]) begin
      d1_d.hdr.side = SIDE_1;
    end else if (match[SIDE_7]) begin
      d1_d.hdr.side = SIDE_7;
    end else if (match[SIDE_3]) begin
      d1_d.hdr.side = SIDE_3;
    end else begin
      d1_d.hdr.side = SIDE_5;
      d1_d.hdr.nos  = 1'b1;
    end

    f0 = $signed(pops_i[0]);
    a2 = $signed(pops_i[map_idx(d1_d.hdr.side, 3'd1)]);
    a3 = $signed(pops_i[map_idx(d1_d.hdr.side, 3'd2)]);
    a4 = $signed(pops_i[map_idx(d1_d.hdr.side, 3'd3)]);
    a6 = $signed(pops_i[map_idx(d1_d.hdr.side, 3'd5)]);
    a7 = $signed(pops_i[map_idx(d1_d.hdr.side, 3'd6)]);

    d1_d.sa = 34'(f0) + 34'(a2) + 34'(a4);
    d1_d.sb = 34'(a3) + 34'(a6) + 34'(a7);
    d1_d.dh = 34'(a2) - 34'(a4) + 34'sd1;
    d1_d.a3 = a3;
    d1_d.a6 = a6;
    d1_d.a7 = a7;
  end

  // Stage 2: saturated density sum, rounded half difference
  always_comb begin
    d2_d.hdr   = d1_q.hdr;
    d2_d.s     = sat40(40'($signed(d1_q.sa)) + (40'($signed(d1_q.sb)) <<< 1));
    d2_d.fx.a3 = d1_q.a3;
    d2_d.fx.a6 = d1_q.a6;
    d2_d.fx.a7 = d1_q.a7;
    d2_d.fx.h  = $signed(d1_q.dh[33:1]);
  end

  assign rdy2       = ~v2_q | out_ready_i;
  assign rdy1       = ~v1_q | rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy1) d1_q <= d1_d;
    if (v1_q && rdy2)       d2_q <= d2_d;
  end

  assign out_valid_o = v2_q;
  assign out_data_o  = d2_q;

endmodule

`default_nettype wire

### src/zhb_weight.sv
// ----------------------------------------------------------------------------
// zhb_weight
// Stages 3-4: boundary weight w from the density sum (pressure or velocity
// mode), then offset dividends for the divide-by-three unit.
// ----------------------------------------------------------------------------
`default_nettype none

module zhb_weight (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  zhb_pkg::s2_t      in_data_i,
  input  zhb_pkg::bmode_e   mode_i,
  input  zhb_pkg::q_t       pressure_i,
  input  zhb_pkg::q_t       gain_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output zhb_pkg::s4_t      out_data_o
);
  import zhb_pkg::*;

  localparam logic signed [63:0] RND = 64'sd1 <<< (QFRAC - 1);

  logic               v3_q, v4_q;
  logic               rdy3, rdy4;
  s3_t                d3_d, d3_q;
  s4_t                d4_d, d4_q;
  logic signed [63:0] rsum;
  q_t                 w;
  logic signed [32:0] x1;
  logic signed [32:0] w3;
  logic signed [YW:0] y1_full, y2_full;

  // Stage 3: product s*G
  always_comb begin
    d3_d.hdr  = in_data_i.hdr;
    d3_d.s    = in_data_i.s;
    d3_d.fx   = in_data_i.fx;
    d3_d.prod = 64'($signed(in_data_i.s)) * 64'($signed(gain_i));
  end

  // Stage 4: select w, form 2w+1 and floor((w+3)/2), shift to nonnegative
  always_comb begin
    rsum = d3_q.prod + RND;
    unique case (mode_i)
      MODE_PRESSURE: w = sat40(40'($signed(pressure_i)) - 40'($signed(d3_q.s)));
      MODE_VELOCITY: w = sat40($signed(rsum[63:QFRAC]));
      default:       w = sat40($signed(rsum[63:QFRAC]));
    endcase
    x1      = $signed({w, 1'b1});
    w3      = 33'(w) + 33'sd3;
    y1_full = (YW+1)'(x1) + Y_OFS;
    y2_full = (YW+1)'($signed(w3[32:1])) + Y_OFS;

    d4_d.hdr = d3_q.hdr;
    d4_d.fx  = d3_q.fx;
    d4_d.y1  = y1_full[YW-1:0];
    d4_d.y2  = y2_full[YW-1:0];
  end

  assign rdy4       = ~v4_q | out_ready_i;
  assign rdy3       = ~v3_q | rdy4;
  assign in_ready_o = rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy3) v3_q <= in_valid_i;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy3) d3_q <= d3_d;
    if (v3_q && rdy4)       d4_q <= d4_d;
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = d4_q;

endmodule

`default_nettype wire

### src/zhb_div3.sv
// ----------------------------------------------------------------------------
// zhb_div3
// Stages 5-6: two floor divisions by three on 35-bit offset dividends,
// split into a high and a low chunk, giving round(2w/3) and round(w/6).
// ----------------------------------------------------------------------------
`default_nettype none

module zhb_div3 (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  zhb_pkg::s4_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output zhb_pkg::s6_t  out_data_o
);
  import zhb_pkg::*;

  logic              v5_q, v6_q;
  logic              rdy5, rdy6;
  s5_t               d5_d, d5_q;
  s6_t               d6_d, d6_q;
  logic [DIV3_W-1:0] qh1, qh2, ql1, ql2;
  logic [YHI-1:0]    rh1, rh2;
  logic [YW-1:0]     q1, q2;
  logic signed [YW:0] t1, t2;

  // Stage 5: high chunk quotient and remainder
  always_comb begin
    qh1 = div3(DIV3_W'(in_data_i.y1[YW-1:YLO]));
    qh2 = div3(DIV3_W'(in_data_i.y2[YW-1:YLO]));
    rh1 = in_data_i.y1[YW-1:YLO] - YHI'(qh1 * 3);
    rh2 = in_data_i.y2[YW-1:YLO] - YHI'(qh2 * 3);

    d5_d.hdr = in_data_i.hdr;
    d5_d.fx  = in_data_i.fx;
    d5_d.qh1 = qh1[YHI-1:0];
    d5_d.qh2 = qh2[YHI-1:0];
    d5_d.n1  = {rh1[1:0], in_data_i.y1[YLO-1:0]};
    d5_d.n2  = {rh2[1:0], in_data_i.y2[YLO-1:0]};
  end

  // Stage 6: low chunk quotient, join, remove the offset
  always_comb begin
    ql1 = div3(d5_q.n1);
    ql2 = div3(d5_q.n2);
    q1  = {d5_q.qh1, {YLO{1'b0}}} + YW'(ql1[YLO-1:0]);
    q2  = {d5_q.qh2, {YLO{1'b0}}} + YW'(ql2[YLO-1:0]);
    t1  = $signed({1'b0, q1}) - Q_OFS;
    t2  = $signed({1'b0, q2}) - Q_OFS;

    d6_d.hdr = d5_q.hdr;
    d6_d.fx  = d5_q.fx;
    d6_d.t23 = $signed(t1[QW-1:0]);
    d6_d.w6  = $signed(t2[QW-1:0]);
  end

  assign rdy6       = ~v6_q | out_ready_i;
  assign rdy5       = ~v5_q | rdy6;
  assign in_ready_o = rdy5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (rdy5) v5_q <= in_valid_i;
      if (rdy6) v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy5) d5_q <= d5_d;
    if (v5_q && rdy6)       d6_q <= d6_d;
  end

  assign out_valid_o = v6_q;
  assign out_data_o  = d6_q;

endmodule

`default_nettype wire

### src/zou_he_d2q9_boundary.sv
// ----------------------------------------------------------------------------
// zou_he_d2q9_boundary
// D2Q9 Zou-He open boundary: rebuilds the three unknown populations of a
// boundary cell in Q8.24, velocity or pressure mode.
// ----------------------------------------------------------------------------
//  Channel   Handshake                  Payload
//  -------   -------------------------  -----------------------------------
//  input     in_valid_i / in_ready_o    pop_0_i..pop_8_i, neighbour flags
//  output    out_valid_o / out_ready_i  out_pop_0_o..out_pop_8_o, side flags
//  config    cfg_we_i (no wait)         cfg_index_i, cfg_data_i
//
//  Seven register stages; one cell per cycle sustained while out_ready_i stays high.
//  Stage 3 (32x32 multiply) and stages 5-6 (divide by three in two chunks)
//  set the depth.
//  Reset clears all stage valid bits and the configuration registers.
//  Each stage holds its request while the next stage is full and stalled;
//  empty stages still fill, so bubbles close up behind a stalled output.
// ----------------------------------------------------------------------------
`default_nettype none

module zou_he_d2q9_boundary (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  zhb_pkg::cfg_idx_t  cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] pop_0_i,
  input  logic signed [31:0] pop_1_i,
  input  logic signed [31:0] pop_2_i,
  input  logic signed [31:0] pop_3_i,
  input  logic signed [31:0] pop_4_i,
  input  logic signed [31:0] pop_5_i,
  input  logic signed [31:0] pop_6_i,
  input  logic signed [31:0] pop_7_i,
  input  logic signed [31:0] pop_8_i,
  input  logic [3:0]         neighbour_present_i,
  input  logic [3:0]         neighbour_fluid_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_pop_0_o,
  output logic signed [31:0] out_pop_1_o,
  output logic signed [31:0] out_pop_2_o,
  output logic signed [31:0] out_pop_3_o,
  output logic signed [31:0] out_pop_4_o,
  output logic signed [31:0] out_pop_5_o,
  output logic signed [31:0] out_pop_6_o,
  output logic signed [31:0] out_pop_7_o,
  output logic signed [31:0] out_pop_8_o,
  output logic [1:0]         open_side_o,
  output logic               no_open_side_o
);
  import zhb_pkg::*;

  bmode_e   mode_q;
  q_t       pressure_q;
  q_t       gain_q;

  pop_vec_t in_pops;
  logic     v2, r2, v4, r4, v6, r6;
  s2_t      d2;
  s4_t      d4;
  s6_t      d6;

  logic     v7_q;
  hdr_t     d7_d, d7_q;
  q_t       o1, o5, o8;
  logic [3:0] i1, i5, i8;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_VELOCITY;
      pressure_q <= '0;
      gain_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MODE:     mode_q     <= bmode_e'(cfg_data_i[0]);
        CFG_PRESSURE: pressure_q <= $signed(cfg_data_i);
        CFG_GAIN:     gain_q     <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign in_pops = {pop_8_i, pop_7_i, pop_6_i, pop_5_i, pop_4_i,
                    pop_3_i, pop_2_i, pop_1_i, pop_0_i};

  zhb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pops_i      (in_pops),
    .present_i   (neighbour_present_i),
    .fluid_i     (neighbour_fluid_i),
    .out_valid_o (v2),
    .out_ready_i (r2),
    .out_data_o  (d2)
  );

  zhb_weight u_weight (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v2),
    .in_ready_o  (r2),
    .in_data_i   (d2),
    .mode_i      (mode_q),
    .pressure_i  (pressure_q),
    .gain_i      (gain_q),
    .out_valid_o (v4),
    .out_ready_i (r4),
    .out_data_o  (d4)
  );

  zhb_div3 u_div3 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v4),
    .in_ready_o  (r4),
    .in_data_i   (d4),
    .out_valid_o (v6),
    .out_ready_i (r6),
    .out_data_o  (d6)
  );

  // Stage 7: final saturated updates, write back into i1, i5, i8
  always_comb begin
    o1 = sat40(40'($signed(d6.fx.a3)) + 40'($signed(d6.t23)));
    o5 = sat40(40'($signed(d6.fx.a7)) - 40'($signed(d6.fx.h))
               + 40'($signed(d6.w6)));
    o8 = sat40(40'($signed(d6.fx.a6)) + 40'($signed(d6.fx.h))
               + 40'($signed(d6.w6)));
    i1 = map_idx(d6.hdr.side, 3'd0);
    i5 = map_idx(d6.hdr.side, 3'd4);
    i8 = map_idx(d6.hdr.side, 3'd7);

    d7_d = d6.hdr;
    for (int k = 0; k < NPOP; k++) begin
      if (!d6.hdr.nos && i1 == 4'(k)) d7_d.pops[k] = o1;
      if (!d6.hdr.nos && i5 == 4'(k)) d7_d.pops[k] = o5;
      if (!d6.hdr.nos && i8 == 4'(k)) d7_d.pops[k] = o8;
    end
  end

  assign r6 = ~v7_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else if (r6) begin
      v7_q <= v6;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v6 && r6) d7_q <= d7_d;
  end

  assign out_valid_o    = v7_q;
  assign out_pop_0_o    = $signed(d7_q.pops[0]);
  assign out_pop_1_o    = $signed(d7_q.pops[1]);
  assign out_pop_2_o    = $signed(d7_q.pops[2]);
  assign out_pop_3_o    = $signed(d7_q.pops[3]);
  assign out_pop_4_o    = $signed(d7_q.pops[4]);
  assign out_pop_5_o    = $signed(d7_q.pops[5]);
  assign out_pop_6_o    = $signed(d7_q.pops[6]);
  assign out_pop_7_o    = $signed(d7_q.pops[7]);
  assign out_pop_8_o    = $signed(d7_q.pops[8]);
  assign open_side_o    = d7_q.side;
  assign no_open_side_o = d7_q.nos;

  // A cell with no open side reports side code zero
  a_nos_side : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && no_open_side_o) |-> (open_side_o == SIDE_5))
    else $error("no open side but side code nonzero");

  // Direction 0 is never an unknown and must pass through the final stage
  a_pop0_pass : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v6 && r6) |=> (d7_q.pops[0] == $past(d6.hdr.pops[0])))
    else $error("population 0 altered by write back");

  // Without an open side every population passes unchanged
  a_nos_pass : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v6 && r6 && d6.hdr.nos) |=> (d7_q.pops == $past(d6.hdr.pops)))
    else $error("populations altered with no open side");

endmodule

`default_nettype wire

### bench/boundary_cell_checker.sv
// ----------------------------------------------------------------------------
// boundary_cell_checker
// Watches the cell and result channels of the Zou-He boundary, rebuilds each
// accepted cell in software and compares every result field by field.
// ----------------------------------------------------------------------------
module boundary_cell_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  zhb_pkg::cfg_idx_t cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  zhb_pkg::pop_vec_t pops_i,
  input  logic [3:0]        present_i,
  input  logic [3:0]        fluid_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  zhb_pkg::pop_vec_t out_pops_i,
  input  zhb_pkg::side_t    open_side_i,
  input  logic              no_open_side_i,
  output int                mismatches_o,
  output int                pending_o,
  output int                checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import zhb_pkg::*;

  // neighbour flag bit of each lattice direction
  localparam int NB_1 = 0;
  localparam int NB_3 = 1;
  localparam int NB_5 = 2;
  localparam int NB_7 = 3;

  localparam longint Q_HI = 64'sd2147483647;
  localparam longint Q_LO = -64'sd2147483648;

  typedef struct packed {
    pop_vec_t pops;
    side_t    side;
    logic     no_side;
  } cell_result_t;

  cell_result_t expected_cells [$];
  bmode_e       mode_q;
  logic [31:0]  level_q;
  logic [31:0]  gain_q;
  int           mismatch_count;
  int           checked_count;
  int           pending_count;

  assign mismatches_o = mismatch_count;
  assign pending_o    = pending_count;
  assign checked_o    = checked_count;

  function automatic longint clamp_q(input longint v);
    if (v > Q_HI) return Q_HI;
    if (v < Q_LO) return Q_LO;
    return v;
  endfunction

  // division rounding toward minus infinity, positive divisor only
  function automatic longint floor_div(input longint num, input longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  // population index at position i1..i8 (pos 0..7) for one open side
  function automatic int dir_of(input side_t side, input int pos);
    logic [31:0] row;
    case (side)
      SIDE_5:  row = 32'h1357_2468;
      SIDE_1:  row = 32'h5317_4286;
      SIDE_7:  row = 32'h3571_4682;
      default: row = 32'h7135_8246;
    endcase
    return int'(row[31-4*pos -: 4]);
  endfunction

  function automatic cell_result_t rebuild_cell(input pop_vec_t pops,
                                                input logic [3:0] pres,
                                                input logic [3:0] fluid);
    cell_result_t r;
    longint       f [9];
    logic [3:0]   wet;
    int           k;
    int           own;
    int           opp;
    int           found;
    side_t        sd;
    longint       a2, a3, a4, a6, a7, s, w, t23, w6, h;

    found = -1;
    wet   = fluid & pres;
    for (k = 0; k < 9; k++) f[k] = longint'($signed(pops[k]));

    // first side in priority order whose neighbour is absent or solid
    // facing fluid on the opposite side
    for (k = 0; k < 4 && found < 0; k++) begin
      case (side_t'(k))
        SIDE_5: begin own = NB_5; opp = NB_1; end
        SIDE_1: begin own = NB_1; opp = NB_5; end
        SIDE_7: begin own = NB_7; opp = NB_3; end
        default: begin own = NB_3; opp = NB_7; end
      endcase
      if (!pres[own] || (!wet[own] && wet[opp])) found = k;
    end

    if (found >= 0) begin
      sd = side_t'(found);
      a2 = f[dir_of(sd, 1)];
      a3 = f[dir_of(sd, 2)];
      a4 = f[dir_of(sd, 3)];
      a6 = f[dir_of(sd, 5)];
      a7 = f[dir_of(sd, 6)];
      s  = clamp_q(f[0] + a2 + a4 + 2 * (a3 + a6 + a7));
      if (mode_q == MODE_PRESSURE) begin
        w = clamp_q(longint'($signed(level_q)) - s);
      end else begin
        w = clamp_q((s * longint'($signed(gain_q)) + (longint'(1) << (QFRAC - 1)))
                    >>> QFRAC);
      end
      t23 = floor_div(4 * w + 3, 6);
      w6  = floor_div(2 * w + 6, 12);
      h   = floor_div(a2 - a4 + 1, 2);
      f[dir_of(sd, 0)] = clamp_q(a3 + t23);
      f[dir_of(sd, 4)] = clamp_q(a7 - h + w6);
      f[dir_of(sd, 7)] = clamp_q(a6 + h + w6);
      r.side    = sd;
      r.no_side = 1'b0;
    end else begin
      r.side    = SIDE_5;
      r.no_side = 1'b1;
    end
    for (k = 0; k < 9; k++) r.pops[k] = 32'(f[k]);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: result %0d, %s: got %h, want %h", $time, checked_count, what,
             got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cell_result_t want;
    int           k;
    if (!rst_ni) begin
      mode_q         = MODE_VELOCITY;
      level_q        = '0;
      gain_q         = '0;
      mismatch_count = 0;
      checked_count  = 0;
      pending_count  = 0;
      expected_cells.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        expected_cells.push_back(rebuild_cell(pops_i, present_i, fluid_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_cells.size() == 0) begin
          report_mismatch("result with no cell outstanding", out_pops_i[0], '0);
        end else begin
          want = expected_cells.pop_front();
          for (k = 0; k < 9; k++) begin
            if (out_pops_i[k] !== want.pops[k]) begin
              report_mismatch($sformatf("out_pop_%0d", k), out_pops_i[k], want.pops[k]);
            end
          end
          if (open_side_i !== want.side) begin
            report_mismatch("open_side", 32'(open_side_i), 32'(want.side));
          end
          if (no_open_side_i !== want.no_side) begin
            report_mismatch("no_open_side", 32'(no_open_side_i), 32'(want.no_side));
          end
        end
        checked_count++;
      end
      pending_count = expected_cells.size();
      // registers only change while no cell is in flight
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MODE:     mode_q  = bmode_e'(cfg_data_i[0]);
          CFG_PRESSURE: level_q = cfg_data_i;
          CFG_GAIN:     gain_q  = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

### bench/tb_zou_he_d2q9_boundary.sv
// ----------------------------------------------------------------------------
// tb_zou_he_d2q9_boundary
// Streams boundary cells through the Zou-He block under velocity and pressure
// settings, with random gaps and output stalls; the checker scores results.
// ----------------------------------------------------------------------------
module tb_zou_he_d2q9_boundary;
  timeunit 1ns;
  timeprecision 1ps;

  import zhb_pkg::*;

  localparam int          DIRECTED_CELLS  = 12;
  localparam int          NUM_PHASES      = 8;
  localparam int          CELLS_PER_PHASE = 115;
  localparam int          QUIET_LIMIT     = 1000;
  localparam int          DRAIN_CYCLES    = 20;
  localparam logic [31:0] Q_MAX           = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN           = 32'h8000_0000;
  localparam logic [31:0] Q_ONE           = 32'h0100_0000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  cfg_idx_t    cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  pop_vec_t    cell_pops;
  logic [3:0]  nb_present;
  logic [3:0]  nb_fluid;
  logic        out_valid;
  logic        out_ready;
  wire [8:0][31:0] result_pops;
  side_t       open_side;
  logic        no_open_side;
  int          mismatches;
  int          pending;
  int          checked;
  int          cells_sent;
  int          settings_used;
  bit          send_burst;
  bit          recv_burst;

  zou_he_d2q9_boundary u_top (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .pop_0_i             (cell_pops[0]),
    .pop_1_i             (cell_pops[1]),
    .pop_2_i             (cell_pops[2]),
    .pop_3_i             (cell_pops[3]),
    .pop_4_i             (cell_pops[4]),
    .pop_5_i             (cell_pops[5]),
    .pop_6_i             (cell_pops[6]),
    .pop_7_i             (cell_pops[7]),
    .pop_8_i             (cell_pops[8]),
    .neighbour_present_i (nb_present),
    .neighbour_fluid_i   (nb_fluid),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .out_pop_0_o         (result_pops[0]),
    .out_pop_1_o         (result_pops[1]),
    .out_pop_2_o         (result_pops[2]),
    .out_pop_3_o         (result_pops[3]),
    .out_pop_4_o         (result_pops[4]),
    .out_pop_5_o         (result_pops[5]),
    .out_pop_6_o         (result_pops[6]),
    .out_pop_7_o         (result_pops[7]),
    .out_pop_8_o         (result_pops[8]),
    .open_side_o         (open_side),
    .no_open_side_o      (no_open_side)
  );

  boundary_cell_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .pops_i         (cell_pops),
    .present_i      (nb_present),
    .fluid_i        (nb_fluid),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_pops_i     (result_pops),
    .open_side_i    (open_side),
    .no_open_side_i (no_open_side),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: stall a random number of cycles before each result
  initial begin
    int stall;
    out_ready  = 1'b0;
    recv_burst = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // End the run if neither channel moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no request moved for %0d cycles", QUIET_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Call at a falling edge; returns at a falling edge after acceptance
  task automatic send_cell(input pop_vec_t pops, input logic [3:0] pres,
                           input logic [3:0] fluid);
    int gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    cell_pops  <= pops;
    nb_present <= pres;
    nb_fluid   <= fluid;
    do @(posedge clk); while (!in_ready);
    cells_sent++;
    @(negedge clk);
  endtask

  // Drop valid and hold until every outstanding result is back
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic apply_setting(input bmode_e mode, input logic [31:0] level,
                               input logic [31:0] gain);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_data  <= 32'(mode);
    @(negedge clk);
    cfg_index <= CFG_PRESSURE;
    cfg_data  <= level;
    @(negedge clk);
    cfg_index <= CFG_GAIN;
    cfg_data  <= gain;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic void directed_cell(input int idx, output pop_vec_t pops,
                                        output logic [3:0] pres,
                                        output logic [3:0] fluid);
    int k;
    for (k = 0; k < 9; k++) begin
      case (idx)
        0:       pops[k] = '0;
        1:       pops[k] = Q_MAX;
        2:       pops[k] = Q_MIN;
        3:       pops[k] = (k % 2 == 0) ? Q_MAX : Q_MIN;
        4:       pops[k] = Q_ONE;
        5:       pops[k] = 32'h0040_0000 * k;
        6:       pops[k] = -(k + 1);
        7:       pops[k] = Q_ONE >> k;
        8:       pops[k] = 32'h5555_5555;
        9:       pops[k] = (k % 2 == 1) ? 32'h0000_0001 : 32'hFFFF_FFFF;
        10:      pops[k] = (k % 2 == 0) ? Q_MIN : Q_MAX;
        default: pops[k] = 32'hAAAA_AAAA;
      endcase
    end
    pres = 4'hF;
    case (idx)
      0:       fluid = 4'hF;  // all neighbours fluid: no open side
      1:       fluid = 4'hB;
      2:       fluid = 4'hE;
      3:       fluid = 4'h7;
      4:       fluid = 4'hD;
      5:       begin pres = 4'hB; fluid = 4'hF; end  // direction 5 absent
      6:       begin pres = 4'h7; fluid = 4'hF; end  // absent but flagged fluid
      7:       begin pres = 4'h0; fluid = 4'hF; end
      8:       fluid = 4'h0;  // all solid: no open side
      9:       fluid = 4'hB;  // alternating +1 and -1 populations
      10:      fluid = 4'hE;
      default: fluid = 4'hD;
    endcase
  endfunction

  function automatic logic [31:0] random_pop();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      6, 7:    v = $urandom;
      8:       v = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      9:       v = 32'($signed($urandom_range(0, 2)) - 1);
      default: v = 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
    endcase
    return v;
  endfunction

  initial begin
    pop_vec_t   pops;
    logic [3:0] pres;
    logic [3:0] fluid;
    int         p;
    int         n;
    int         k;

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_MODE;
    cfg_data      = '0;
    in_valid      = 1'b0;
    cell_pops     = '0;
    nb_present    = '0;
    nb_fluid      = '0;
    cells_sent    = 0;
    settings_used = 0;
    send_burst    = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed cells under the harshest velocity and pressure settings
    apply_setting(MODE_VELOCITY, '0, Q_MAX);
    for (n = 0; n < DIRECTED_CELLS; n++) begin
      directed_cell(n, pops, pres, fluid);
      send_cell(pops, pres, fluid);
    end
    settle();
    apply_setting(MODE_PRESSURE, Q_MIN, '0);
    for (n = 0; n < DIRECTED_CELLS; n++) begin
      directed_cell(n, pops, pres, fluid);
      send_cell(pops, pres, fluid);
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      case (p)
        0: apply_setting(MODE_VELOCITY, '0, '0);
        1: apply_setting(MODE_VELOCITY, $urandom, 32'h0019_999A);
        2: apply_setting(MODE_VELOCITY, $urandom, Q_MAX);
        3: apply_setting(MODE_VELOCITY, $urandom, Q_MIN);
        4: apply_setting(MODE_PRESSURE, Q_ONE, $urandom);
        5: apply_setting(MODE_PRESSURE, Q_MAX, $urandom);
        6: apply_setting(MODE_PRESSURE, Q_MIN, $urandom);
        default: apply_setting(bmode_e'($urandom_range(0, 1)), $urandom, $urandom);
      endcase
      for (n = 0; n < CELLS_PER_PHASE; n++) begin
        // drain the pipeline once mid-stream
        if (p == 3 && n == CELLS_PER_PHASE / 2) settle();
        for (k = 0; k < 9; k++) pops[k] = random_pop();
        pres  = ($urandom_range(0, 2) == 0) ? 4'hF : 4'($urandom);
        fluid = 4'($urandom);
        send_cell(pops, pres, fluid);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d boundary cells under %0d register settings, both modes,",
             cells_sent, settings_used);
    $display("level and gain at both extremes; %0d results compared, %0d mismatches",
             checked, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
